FILE: rtl/gds_pkg.sv
// Shared types, constants, calendar helpers and control store of the date stepper.
`timescale 1ns / 1ps

package gds_pkg;

  // Default widths of the year and day-count fields
  localparam int YEAR_BITS_DEF  = 12;
  localparam int COUNT_BITS_DEF = 20;
  // Width of the reported day distance (wraps at this width)
  localparam int DIST_BITS      = 21;
  // Widest supported year; the leap test works at this width
  localparam int LEAP_BITS      = 16;
  localparam int RESET_YEAR     = 1900;

  // Divisibility by 25 through the inverse of 25 modulo 2^LEAP_BITS
  localparam logic [LEAP_BITS-1:0] INV25 = 16'd23593;
  localparam logic [LEAP_BITS-1:0] LIM25 = LEAP_BITS'((2 ** LEAP_BITS - 1) / 25);

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_28    = 5'd28;
  localparam logic [4:0] DAY_29    = 5'd29;
  localparam logic [4:0] DAY_30    = 5'd30;
  localparam logic [4:0] DAY_LAST  = 5'd31;

  // Command codes
  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_CMP  = 2'd3
  } mode_t;

  // Datapath operations selected by the control word
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_CAPTURE  = 3'd1,
    OP_LOAD_W   = 3'd2,
    OP_CLAMP    = 3'd3,
    OP_COMPARE  = 3'd4,
    OP_WALK     = 3'd5,
    OP_END_WALK = 3'd6,
    OP_END_LOAD = 3'd7
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER  = 3'd0,
    C_ALWAYS = 3'd1,
    C_START  = 3'd2,
    C_STEP   = 3'd3,
    C_LOAD   = 3'd4,
    C_DONE   = 3'd5
  } cond_t;

  localparam int PC_BITS = 3;
  localparam logic [PC_BITS-1:0] PC_WAIT     = 3'd0;
  localparam logic [PC_BITS-1:0] PC_FETCH    = 3'd1;
  localparam logic [PC_BITS-1:0] PC_CLAMP    = 3'd2;
  localparam logic [PC_BITS-1:0] PC_COMPARE  = 3'd3;
  localparam logic [PC_BITS-1:0] PC_WALK     = 3'd4;
  localparam logic [PC_BITS-1:0] PC_END_WALK = 3'd5;
  localparam logic [PC_BITS-1:0] PC_END_LOAD = 3'd6;

  // One word of the control store
  typedef struct packed {
    op_t                op;
    logic               leap_sel;  // 1: leap test on the given date, 0: on the walker
    cond_t              cond;
    logic               hold;      // stay on this step when the condition fails
    logic [PC_BITS-1:0] target;
  } ucode_t;

  // Controls from sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic leap_sel;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic start;
    logic step_mode;
    logic load_mode;
    logic walk_done;
  } flags_t;

  // Leap by the 4/100/400 rule; 400 = 16 * 25 and 100 = 4 * 25
  function automatic logic leap_year(input logic [LEAP_BITS-1:0] y);
    logic [LEAP_BITS-1:0] prod;
    logic                 by25;
    logic                 by4;
    logic                 by16;
    prod = y * INV25;
    by25 = (prod <= LIM25);
    by4  = (y[1:0] == 2'd0);
    by16 = (y[3:0] == 4'd0);
    return (by4 && !by25) || (by16 && by25);
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_30;
      MONTH_FEB: len = leap ? DAY_29 : DAY_28;
      default:   len = DAY_LAST;
    endcase
    return len;
  endfunction

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    case (pc)
      PC_WAIT:     w = '{op: OP_CAPTURE,  leap_sel: 1'b0, cond: C_START,
                         hold: 1'b1, target: PC_FETCH};
      PC_FETCH:    w = '{op: OP_LOAD_W,   leap_sel: 1'b0, cond: C_STEP,
                         hold: 1'b0, target: PC_WALK};
      PC_CLAMP:    w = '{op: OP_CLAMP,    leap_sel: 1'b1, cond: C_LOAD,
                         hold: 1'b0, target: PC_END_LOAD};
      PC_COMPARE:  w = '{op: OP_COMPARE,  leap_sel: 1'b0, cond: C_NEVER,
                         hold: 1'b0, target: PC_WAIT};
      PC_WALK:     w = '{op: OP_WALK,     leap_sel: 1'b0, cond: C_DONE,
                         hold: 1'b1, target: PC_END_WALK};
      PC_END_WALK: w = '{op: OP_END_WALK, leap_sel: 1'b0, cond: C_ALWAYS,
                         hold: 1'b0, target: PC_WAIT};
      PC_END_LOAD: w = '{op: OP_END_LOAD, leap_sel: 1'b1, cond: C_ALWAYS,
                         hold: 1'b0, target: PC_WAIT};
      default:     w = '{op: OP_NONE,     leap_sel: 1'b0, cond: C_ALWAYS,
                         hold: 1'b0, target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/gds_sequencer.sv
// Step counter and control store that drive the date stepper datapath.
`timescale 1ns / 1ps

module gds_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  gds_pkg::flags_t flags,
  output gds_pkg::ctrl_t  ctrl,
  output logic            busy
);

  logic [gds_pkg::PC_BITS-1:0] pc_r;
  logic [gds_pkg::PC_BITS-1:0] pc_nxt;
  gds_pkg::ucode_t             word;
  logic                        taken;

  // Fetch the current control word
  assign word          = gds_pkg::ucode_rom(pc_r);
  assign ctrl.op       = word.op;
  assign ctrl.leap_sel = word.leap_sel;
  assign busy          = (pc_r != gds_pkg::PC_WAIT);

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      gds_pkg::C_NEVER:  taken = 1'b0;
      gds_pkg::C_ALWAYS: taken = 1'b1;
      gds_pkg::C_START:  taken = flags.start;
      gds_pkg::C_STEP:   taken = flags.step_mode;
      gds_pkg::C_LOAD:   taken = flags.load_mode;
      gds_pkg::C_DONE:   taken = flags.walk_done;
      default:           taken = 1'b1;
    endcase
  end

  // Jump, hold or advance
  always_comb begin
    if (taken) begin
      pc_nxt = word.target;
    end else if (word.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + gds_pkg::PC_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= gds_pkg::PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/gregorian_date_stepper_unit.sv
// Top level of the Gregorian date stepper: command port, date datapath, sequencer.
`timescale 1ns / 1ps

// Keeps one Gregorian date (1 January 1900 after reset) and runs one command per
// transfer, taken when start is high and busy is low. Every command gives exactly
// one result, shown for a single cycle with out_valid high; the receiver cannot
// stall, so it must take the result in that cycle. The kept date and the flags stay
// on the result ports until the next command changes them. A load captures the
// command, clamps the given date and commits it; an add or subtract of N days
// walks N days (fewer when the walk stops at the edge of the year range); a
// compare walks the working date to the given date, D steps for a distance of D
// days. The walking loop moves the working date by one day per cycle.
module gregorian_date_stepper_unit #(
  parameter int YEAR_BITS  = gds_pkg::YEAR_BITS_DEF,
  parameter int COUNT_BITS = gds_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [4:0]                    in_arg_day,
  input  logic [3:0]                    in_arg_month,
  input  logic [YEAR_BITS-1:0]          in_arg_year,
  input  logic [COUNT_BITS-1:0]         in_day_count,
  output logic                          out_valid,
  output logic [4:0]                    out_day,
  output logic [3:0]                    out_month,
  output logic [YEAR_BITS-1:0]          out_year,
  output logic [gds_pkg::DIST_BITS-1:0] out_distance,
  output logic                          out_is_earlier,
  output logic                          out_is_equal,
  output logic                          out_range_error
);

  localparam int YB = YEAR_BITS;
  localparam int CB = COUNT_BITS;
  localparam int DB = gds_pkg::DIST_BITS;
  localparam logic [YB-1:0] YEAR_ONE = YB'(1);
  localparam logic [YB-1:0] YEAR_MAX = {YB{1'b1}};

  gds_pkg::ctrl_t  ctrl;
  gds_pkg::flags_t flags;

  // Kept date
  logic [4:0]    cur_day_r,   cur_day_nxt;
  logic [3:0]    cur_month_r, cur_month_nxt;
  logic [YB-1:0] cur_year_r,  cur_year_nxt;
  // Working date that walks
  logic [4:0]    w_day_r,   w_day_nxt;
  logic [3:0]    w_month_r, w_month_nxt;
  logic [YB-1:0] w_year_r,  w_year_nxt;
  // Given date
  logic [4:0]    g_day_r,   g_day_nxt;
  logic [3:0]    g_month_r, g_month_nxt;
  logic [YB-1:0] g_year_r,  g_year_nxt;

  gds_pkg::mode_t mode_r, mode_nxt;
  logic [CB-1:0]  cnt_r, cnt_nxt;
  logic [DB-1:0]  dist_r, dist_nxt;
  logic           earlier_r, earlier_nxt;
  logic           equal_r, equal_nxt;
  logic           err_r, err_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [YB-1:0] leap_src;
  logic [3:0]    len_month;
  logic          leap;
  logic [4:0]    len_cur;
  logic [4:0]    len_prev;
  logic          w_eq_g;
  logic          w_before_g;
  logic          step_mode;
  logic          dir_back;
  logic          at_limit;
  logic          walk_done;

  gds_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Month length for the selected date
  assign leap_src  = ctrl.leap_sel ? g_year_r : w_year_r;
  assign len_month = ctrl.leap_sel ? g_month_r : w_month_r;
  assign leap      = gds_pkg::leap_year(gds_pkg::LEAP_BITS'(leap_src));
  assign len_cur   = gds_pkg::month_length(len_month, leap);
  assign len_prev  = gds_pkg::month_length(w_month_r - 4'd1, leap);

  // Compare walker with given date
  assign w_eq_g     = (w_year_r == g_year_r) && (w_month_r == g_month_r) &&
                      (w_day_r == g_day_r);
  assign w_before_g = (w_year_r < g_year_r) ||
                      ((w_year_r == g_year_r) && (w_month_r < g_month_r)) ||
                      ((w_year_r == g_year_r) && (w_month_r == g_month_r) &&
                       (w_day_r < g_day_r));

  // Walk direction and stop conditions
  assign step_mode = (mode_r == gds_pkg::MODE_ADD) || (mode_r == gds_pkg::MODE_SUB);
  assign dir_back  = (mode_r == gds_pkg::MODE_SUB) ||
                     ((mode_r == gds_pkg::MODE_CMP) && !earlier_r);
  assign at_limit  = dir_back ?
                     ((w_day_r == gds_pkg::DAY_FIRST) && (w_month_r == gds_pkg::MONTH_JAN) &&
                      (w_year_r == YEAR_ONE)) :
                     ((w_day_r == gds_pkg::DAY_LAST) && (w_month_r == gds_pkg::MONTH_DEC) &&
                      (w_year_r == YEAR_MAX));
  assign walk_done = (mode_r == gds_pkg::MODE_CMP) ? w_eq_g :
                     ((cnt_r == '0) || at_limit);

  assign flags.start     = start;
  assign flags.step_mode = step_mode;
  assign flags.load_mode = (mode_r == gds_pkg::MODE_LOAD);
  assign flags.walk_done = walk_done;

  // Datapath next state
  always_comb begin
    cur_day_nxt   = cur_day_r;
    cur_month_nxt = cur_month_r;
    cur_year_nxt  = cur_year_r;
    w_day_nxt     = w_day_r;
    w_month_nxt   = w_month_r;
    w_year_nxt    = w_year_r;
    g_day_nxt     = g_day_r;
    g_month_nxt   = g_month_r;
    g_year_nxt    = g_year_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    dist_nxt      = dist_r;
    earlier_nxt   = earlier_r;
    equal_nxt     = equal_r;
    err_nxt       = err_r;
    out_valid_nxt = 1'b0;
    case (ctrl.op)
      gds_pkg::OP_CAPTURE: begin
        // Take the command; fix month and year of the given date
        if (start) begin
          mode_nxt    = gds_pkg::mode_t'(in_mode);
          cnt_nxt     = in_day_count;
          g_day_nxt   = in_arg_day;
          g_year_nxt  = (in_arg_year == '0) ? YEAR_ONE : in_arg_year;
          if (in_arg_month == 4'd0) begin
            g_month_nxt = gds_pkg::MONTH_JAN;
          end else if (in_arg_month > gds_pkg::MONTH_DEC) begin
            g_month_nxt = gds_pkg::MONTH_DEC;
          end else begin
            g_month_nxt = in_arg_month;
          end
          dist_nxt    = '0;
          earlier_nxt = 1'b0;
          equal_nxt   = 1'b0;
          err_nxt     = 1'b0;
        end
      end
      gds_pkg::OP_LOAD_W: begin
        w_day_nxt   = cur_day_r;
        w_month_nxt = cur_month_r;
        w_year_nxt  = cur_year_r;
      end
      gds_pkg::OP_CLAMP: begin
        // Pull the given day into its month
        if (g_day_r == 5'd0) begin
          g_day_nxt = gds_pkg::DAY_FIRST;
        end else if (g_day_r > len_cur) begin
          g_day_nxt = len_cur;
        end
      end
      gds_pkg::OP_COMPARE: begin
        earlier_nxt = w_before_g;
        equal_nxt   = w_eq_g;
      end
      gds_pkg::OP_WALK: begin
        // Move the walker one day and count it
        if (!walk_done) begin
          if (dir_back) begin
            if (w_day_r != gds_pkg::DAY_FIRST) begin
              w_day_nxt = w_day_r - 5'd1;
            end else if (w_month_r == gds_pkg::MONTH_JAN) begin
              w_day_nxt   = gds_pkg::DAY_LAST;
              w_month_nxt = gds_pkg::MONTH_DEC;
              w_year_nxt  = w_year_r - YB'(1);
            end else begin
              w_day_nxt   = len_prev;
              w_month_nxt = w_month_r - 4'd1;
            end
          end else begin
            if (w_day_r < len_cur) begin
              w_day_nxt = w_day_r + 5'd1;
            end else if (w_month_r == gds_pkg::MONTH_DEC) begin
              w_day_nxt   = gds_pkg::DAY_FIRST;
              w_month_nxt = gds_pkg::MONTH_JAN;
              w_year_nxt  = w_year_r + YB'(1);
            end else begin
              w_day_nxt   = gds_pkg::DAY_FIRST;
              w_month_nxt = w_month_r + 4'd1;
            end
          end
          if (mode_r == gds_pkg::MODE_CMP) begin
            dist_nxt = dist_r + DB'(1);
          end else begin
            cnt_nxt = cnt_r - CB'(1);
          end
        end
      end
      gds_pkg::OP_END_WALK: begin
        // Commit a step; days left over mean the range edge was hit
        if (step_mode) begin
          cur_day_nxt   = w_day_r;
          cur_month_nxt = w_month_r;
          cur_year_nxt  = w_year_r;
          err_nxt       = (cnt_r != '0);
        end
        out_valid_nxt = 1'b1;
      end
      gds_pkg::OP_END_LOAD: begin
        cur_day_nxt   = g_day_r;
        cur_month_nxt = g_month_r;
        cur_year_nxt  = g_year_r;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control state and kept date
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_day_r   <= gds_pkg::DAY_FIRST;
      cur_month_r <= gds_pkg::MONTH_JAN;
      cur_year_r  <= YB'(gds_pkg::RESET_YEAR);
      out_valid_r <= 1'b0;
    end else begin
      cur_day_r   <= cur_day_nxt;
      cur_month_r <= cur_month_nxt;
      cur_year_r  <= cur_year_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    w_day_r   <= w_day_nxt;
    w_month_r <= w_month_nxt;
    w_year_r  <= w_year_nxt;
    g_day_r   <= g_day_nxt;
    g_month_r <= g_month_nxt;
    g_year_r  <= g_year_nxt;
    mode_r    <= mode_nxt;
    cnt_r     <= cnt_nxt;
    dist_r    <= dist_nxt;
    earlier_r <= earlier_nxt;
    equal_r   <= equal_nxt;
    err_r     <= err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_day         = cur_day_r;
  assign out_month       = cur_month_r;
  assign out_year        = cur_year_r;
  assign out_distance    = dist_r;
  assign out_is_earlier  = earlier_r;
  assign out_is_equal    = equal_r;
  assign out_range_error = err_r;

  // A result only follows work in progress
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a command in progress");

  // An accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not start the sequencer");

  // The kept date changes only together with a result
  a_date_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !($stable(cur_day_r) && $stable(cur_month_r) &&
                       $stable(cur_year_r))) |-> out_valid)
    else $error("kept date changed without a result");

  // Compare flags and range error never come together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_is_earlier || out_is_equal)) |-> !out_range_error)
    else $error("range error raised on a compare");

  // Kept month stays in range
  a_month_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((cur_month_r >= gds_pkg::MONTH_JAN) &&
                   (cur_month_r <= gds_pkg::MONTH_DEC) && (cur_day_r != 5'd0)))
    else $error("kept date out of range");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the Gregorian date stepper: load, step, compare checked per result.
`timescale 1ns / 1ps

module testbench;

  localparam int YB = gds_pkg::YEAR_BITS_DEF;
  localparam int CB = gds_pkg::COUNT_BITS_DEF;
  localparam int DB = gds_pkg::DIST_BITS;
  localparam int NUM_RANDOM = 1030;
  localparam int GAP_MAX = 400;

  // One command as it goes over the input channel
  typedef struct packed {
    gds_pkg::mode_t mode;
    logic [4:0]     day;
    logic [3:0]     month;
    logic [YB-1:0]  year;
    logic [CB-1:0]  count;
  } date_cmd_t;

  typedef struct packed {
    logic [4:0]    day;
    logic [3:0]    month;
    logic [YB-1:0] year;
  } cal_date_t;

  // One result as it comes back on the result ports
  typedef struct packed {
    cal_date_t     kept;
    logic [DB-1:0] distance;
    logic          earlier;
    logic          equal;
    logic          range_error;
  } date_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    in_mode = gds_pkg::MODE_LOAD;
  logic [4:0]    in_arg_day = '0;
  logic [3:0]    in_arg_month = '0;
  logic [YB-1:0] in_arg_year = '0;
  logic [CB-1:0] in_day_count = '0;
  logic          out_valid;
  logic [4:0]    out_day;
  logic [3:0]    out_month;
  logic [YB-1:0] out_year;
  logic [DB-1:0] out_distance;
  logic          out_is_earlier;
  logic          out_is_equal;
  logic          out_range_error;

  date_cmd_t    pending_cmds[$];
  date_result_t expected_results[$];
  cal_date_t    kept_date = '{day: 5'd1, month: 4'd1, year: YB'(gds_pkg::RESET_YEAR)};
  cal_date_t    plan_cursor = '{day: 5'd1, month: 4'd1, year: YB'(gds_pkg::RESET_YEAR)};
  int           plan_budget = 0;
  int           fault_count = 0;
  int           cycle_count = 0;
  int           cycle_limit = 32'h7fff_ffff;
  int           burst_left = 1;
  int           gap_left = 0;

  gregorian_date_stepper_unit #(
    .YEAR_BITS (YB),
    .COUNT_BITS(CB)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_arg_day     (in_arg_day),
    .in_arg_month   (in_arg_month),
    .in_arg_year    (in_arg_year),
    .in_day_count   (in_day_count),
    .out_valid      (out_valid),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_distance   (out_distance),
    .out_is_earlier (out_is_earlier),
    .out_is_equal   (out_is_equal),
    .out_range_error(out_range_error)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Calendar arithmetic on serial day numbers, day 0 being 1 January of year 1
  function automatic bit is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input logic [3:0] m, input int y);
    case (m)
      gds_pkg::MONTH_APR, gds_pkg::MONTH_JUN,
      gds_pkg::MONTH_SEP, gds_pkg::MONTH_NOV: return 30;
      gds_pkg::MONTH_FEB: return is_leap(y) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  function automatic int year_start(input int y);
    int p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic int day_number(input cal_date_t d);
    int s;
    s = year_start(int'(d.year));
    for (int k = 1; k < int'(d.month); k++) s += days_in_month(4'(k), int'(d.year));
    return s + int'(d.day) - 1;
  endfunction

  function automatic cal_date_t date_of(input int s);
    int        yy;
    int        mm;
    int        len;
    cal_date_t d;
    yy = 1 + s / 366;
    mm = 1;
    while (year_start(yy + 1) <= s) yy++;
    s -= year_start(yy);
    forever begin
      len = days_in_month(4'(mm), yy);
      if (s < len || mm == 12) break;
      s -= len;
      mm++;
    end
    d.day = 5'(s + 1);
    d.month = 4'(mm);
    d.year = YB'(yy);
    return d;
  endfunction

  // Pull a given date into the valid range, month first, then day against it
  function automatic cal_date_t clamp_given(input date_cmd_t c);
    cal_date_t d;
    int        len;
    d.year = (c.year == '0) ? YB'(1) : c.year;
    if (c.month == 4'd0) d.month = gds_pkg::MONTH_JAN;
    else if (c.month > gds_pkg::MONTH_DEC) d.month = gds_pkg::MONTH_DEC;
    else d.month = c.month;
    len = days_in_month(d.month, int'(d.year));
    if (c.day == 5'd0) d.day = gds_pkg::DAY_FIRST;
    else if (int'(c.day) > len) d.day = 5'(len);
    else d.day = c.day;
    return d;
  endfunction

  // Expected result of one command applied to the kept date
  function automatic date_result_t apply_command(input date_cmd_t c, input cal_date_t cur);
    date_result_t r;
    int           s;
    int           g;
    int           top;
    int           cnt;
    r = '0;
    r.kept = cur;
    top = year_start(2 ** YB) - 1;
    cnt = int'(c.count);
    s = day_number(cur);
    case (c.mode)
      gds_pkg::MODE_LOAD: r.kept = clamp_given(c);
      gds_pkg::MODE_ADD: begin
        if (cnt > top - s) begin
          s = top;
          r.range_error = 1'b1;
        end else begin
          s += cnt;
        end
        r.kept = date_of(s);
      end
      gds_pkg::MODE_SUB: begin
        if (cnt > s) begin
          s = 0;
          r.range_error = 1'b1;
        end else begin
          s -= cnt;
        end
        r.kept = date_of(s);
      end
      default: begin
        g = day_number(clamp_given(c));
        if (s == g) r.equal = 1'b1;
        else if (s < g) begin
          r.earlier = 1'b1;
          r.distance = DB'(g - s);
        end else begin
          r.distance = DB'(s - g);
        end
      end
    endcase
    return r;
  endfunction

  function automatic void note_fault(input string what, input date_result_t want,
                                     input date_result_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected %0d-%0d-%0d dist %0d early %0b eq %0b err %0b",
               what, want.kept.year, want.kept.month, want.kept.day, want.distance,
               want.earlier, want.equal, want.range_error);
      $display("  got %0d-%0d-%0d dist %0d early %0b eq %0b err %0b",
               got.kept.year, got.kept.month, got.kept.day, got.distance,
               got.earlier, got.equal, got.range_error);
    end
  endfunction

  // Append a command, advance the planning date and add its cycle cost to the budget
  task automatic queue_cmd(input gds_pkg::mode_t m, input int d, input int mo, input int y,
                           input int cnt);
    date_cmd_t    c;
    date_result_t r;
    int           steps;
    c.mode = m;
    c.day = 5'(d);
    c.month = 4'(mo);
    c.year = YB'(y);
    c.count = CB'(cnt);
    r = apply_command(c, plan_cursor);
    steps = day_number(r.kept) - day_number(plan_cursor);
    if (steps < 0) steps = -steps;
    plan_budget += steps + int'(r.distance) + 8 + GAP_MAX;
    plan_cursor = r.kept;
    pending_cmds.push_back(c);
  endtask

  // Present commands in bursts; predict each one at its transfer
  always @(posedge clk) begin
    date_cmd_t    done_cmd;
    date_cmd_t    next_cmd;
    date_result_t res;
    bit           accepted;
    bit           present;
    bit           fresh;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      present = start && !accepted;
      fresh = 1'b0;
      if (accepted) begin
        done_cmd = pending_cmds.pop_front();
        res = apply_command(done_cmd, kept_date);
        kept_date = res.kept;
        expected_results.push_back(res);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
          if ($urandom_range(0, 3) == 0) gap_left = 0;
          else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(50, GAP_MAX);
          else gap_left = $urandom_range(1, 20);
        end
      end
      if (!present) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          present = 1'b1;
          fresh = 1'b1;
          next_cmd = pending_cmds[0];
        end
      end
      // Hold the fields of a waiting command; put noise on them while idle
      if (fresh) begin
        in_mode <= next_cmd.mode;
        in_arg_day <= next_cmd.day;
        in_arg_month <= next_cmd.month;
        in_arg_year <= next_cmd.year;
        in_day_count <= next_cmd.count;
      end else if (!present) begin
        in_mode <= 2'($urandom);
        in_arg_day <= 5'($urandom);
        in_arg_month <= 4'($urandom);
        in_arg_year <= YB'($urandom);
        in_day_count <= CB'($urandom);
      end
      start <= present;
    end
  end

  // Check every strobed result against the oldest prediction
  always @(posedge clk) begin
    date_result_t want;
    date_result_t got;
    if (rst_n && out_valid) begin
      got.kept.day = out_day;
      got.kept.month = out_month;
      got.kept.year = out_year;
      got.distance = out_distance;
      got.earlier = out_is_earlier;
      got.equal = out_is_equal;
      got.range_error = out_range_error;
      if (expected_results.size() == 0) begin
        note_fault("result with no command outstanding", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) note_fault("result mismatch", want, got);
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < cycle_limit) @(posedge clk);
    $display("** gregorian_date_stepper_unit: FAILED **");
    $finish;
  end

  initial begin
    int pick;
    int room;
    int yv;

    // Reset state, zero counts, leap rules, January 2, range edges, clamping
    queue_cmd(gds_pkg::MODE_CMP, 1, 1, gds_pkg::RESET_YEAR, 0);
    queue_cmd(gds_pkg::MODE_ADD, 0, 0, 0, 0);
    queue_cmd(gds_pkg::MODE_SUB, 0, 0, 0, 0);
    queue_cmd(gds_pkg::MODE_LOAD, 29, 2, 2000, 0);
    queue_cmd(gds_pkg::MODE_ADD, 0, 0, 0, 1);
    queue_cmd(gds_pkg::MODE_LOAD, 28, 2, 1900, 0);
    queue_cmd(gds_pkg::MODE_ADD, 0, 0, 0, 1);
    queue_cmd(gds_pkg::MODE_LOAD, 28, 2, 2024, 0);
    queue_cmd(gds_pkg::MODE_ADD, 0, 0, 0, 1);
    queue_cmd(gds_pkg::MODE_LOAD, 2, 1, 2024, 0);
    queue_cmd(gds_pkg::MODE_SUB, 0, 0, 0, 1);
    queue_cmd(gds_pkg::MODE_SUB, 0, 0, 0, 1);
    queue_cmd(gds_pkg::MODE_ADD, 0, 0, 0, 366);
    queue_cmd(gds_pkg::MODE_LOAD, 0, 0, 0, 0);
    queue_cmd(gds_pkg::MODE_SUB, 0, 0, 0, 5);
    queue_cmd(gds_pkg::MODE_SUB, 31, 15, 4095, 32'hFFFFF);
    queue_cmd(gds_pkg::MODE_LOAD, 31, 15, 4095, 32'hFFFFF);
    queue_cmd(gds_pkg::MODE_ADD, 0, 0, 0, 1);
    queue_cmd(gds_pkg::MODE_ADD, 31, 15, 4095, 32'hFFFFF);
    queue_cmd(gds_pkg::MODE_LOAD, 31, 2, 2100, 0);
    queue_cmd(gds_pkg::MODE_CMP, 0, 13, 2100, 0);
    queue_cmd(gds_pkg::MODE_CMP, 1, 1, 2100, 32'hFFFFF);
    queue_cmd(gds_pkg::MODE_LOAD, 31, 4, 2023, 0);
    queue_cmd(gds_pkg::MODE_SUB, 0, 0, 0, 120);

    // Random commands, mostly short walks and nearby compares
    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        case ($urandom_range(0, 9))
          0, 1: yv = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2)
                                                 : $urandom_range(4094, 4095);
          2: yv = $urandom_range(0, 4095);
          default: yv = $urandom_range(1, 4095);
        endcase
        queue_cmd(gds_pkg::MODE_LOAD, $urandom_range(0, 31), $urandom_range(0, 15), yv,
                  $urandom);
      end else if (pick < 17) begin
        room = (pick < 10) ? year_start(2 ** YB) - 1 - day_number(plan_cursor)
                           : day_number(plan_cursor);
        if (room < 600 && $urandom_range(0, 1) == 0) yv = $urandom_range(0, 2 ** CB - 1);
        else
          case ($urandom_range(0, 9))
            0: yv = $urandom_range(0, 2);
            7, 8, 9: yv = $urandom_range(61, 900);
            default: yv = $urandom_range(0, 60);
          endcase
        queue_cmd((pick < 10) ? gds_pkg::MODE_ADD : gds_pkg::MODE_SUB, $urandom, $urandom,
                  $urandom, yv);
      end else begin
        yv = int'(plan_cursor.year) + $urandom_range(0, 4) - 2;
        if (yv < 0) yv = 0;
        if (yv > 2 ** YB - 1) yv = 2 ** YB - 1;
        queue_cmd(gds_pkg::MODE_CMP, $urandom_range(0, 31), $urandom_range(0, 15), yv,
                  $urandom);
      end
    end

    cycle_limit = 4 * plan_budget + 20000;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (fault_count == 0) begin
      $display("** gregorian_date_stepper_unit: PASSED **");
    end else begin
      $display("** gregorian_date_stepper_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gds_pkg.sv
rtl/gds_sequencer.sv
rtl/gregorian_date_stepper_unit.sv
dv/testbench.sv
